[sv/pidalt_pkg.sv]
// Shared types, constants and fixed-point helpers for the PID altitude controller.
// No dependencies; imported by the multiplier, divider, top level and testbench.
package pidalt_pkg;

  localparam int DATA_W = 32;
  localparam int Q_FRAC = 16;
  localparam int PROD_W = 2 * DATA_W;
  // dividend is |error difference| (33 bits) scaled by 2^16
  localparam int DIV_W  = DATA_W + 1 + Q_FRAC;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd5;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL_E,
    S_INT_ADD,
    S_INT_CLAMP,
    S_MUL_P,
    S_MUL_I,
    S_WAIT_D,
    S_MUL_D,
    S_CLAMP,
    S_DONE
  } state_t;

  // full product >>> 16 (floor), saturated to 32 bits
  function automatic logic signed [DATA_W-1:0] q_sat(input logic [PROD_W-1:0] p);
    logic hi_ones;
    logic hi_zero;
    hi_ones = &p[PROD_W-1:DATA_W+Q_FRAC-1];
    hi_zero = ~|p[PROD_W-1:DATA_W+Q_FRAC-1];
    if (p[PROD_W-1] && !hi_ones) begin
      q_sat = S32_MIN;
    end else if (!p[PROD_W-1] && !hi_zero) begin
      q_sat = S32_MAX;
    end else begin
      q_sat = p[DATA_W+Q_FRAC-1:Q_FRAC];
    end
  endfunction

  // signed quotient from magnitude and sign, saturated to 32 bits
  function automatic logic signed [DATA_W-1:0] quot_sat(input logic [DIV_W-1:0] q,
                                                         input logic neg);
    logic signed [DATA_W-1:0] res;
    if (!neg) begin
      if (|q[DIV_W-1:DATA_W-1]) res = S32_MAX;
      else res = q[DATA_W-1:0];
    end else begin
      if ((|q[DIV_W-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]))) res = S32_MIN;
      else res = -q[DATA_W-1:0];
    end
    quot_sat = res;
  endfunction

endpackage

[sv/pidalt_mul.sv]
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
// Depends on pidalt_pkg for widths.
module pidalt_mul import pidalt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     busy,
  output logic [PROD_W-1:0]        product
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] hi;
  logic [DATA_W-1:0] lo;
  logic [DATA_W:0]   addend;
  logic [DATA_W:0]   sum;
  logic              last;

  assign busy = (count != '0);
  assign last = (count == CNT_W'(1));
  assign product = {hi, lo};

  // multiplier sign bit carries negative weight: subtract on the last step
  always_comb begin
    addend = lo[0] ? {a_q[DATA_W-1], a_q} : '0;
    if (last) sum = {hi[DATA_W-1], hi} - addend;
    else sum = {hi[DATA_W-1], hi} + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(DATA_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= sum[DATA_W:1];
      lo <= {sum[0], lo[DATA_W-1:1]};
    end
  end

endmodule

[sv/pidalt_div.sv]
// Bit-serial restoring divider: unsigned dividend by positive 31-bit divisor.
// One quotient bit per cycle; depends on pidalt_pkg for widths.
module pidalt_div import pidalt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [DATA_W-2:0]   divisor,
  output logic                busy,
  output logic [DIV_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]  count;
  logic [DIV_W-1:0]  dvd;
  logic [DATA_W-2:0] dvs;
  logic [DATA_W-2:0] rem;
  logic [DATA_W-1:0] trial;
  logic [DATA_W-1:0] diff;
  logic              ge;

  assign busy = (count != '0);
  assign quotient = dvd;

  always_comb begin
    trial = {rem, dvd[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(DIV_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DATA_W-2:0] : trial[DATA_W-2:0];
      dvd <= {dvd[DIV_W-2:0], ge};
    end
  end

endmodule

[sv/pid_altitude_controller.sv]
// Top level of the Q16.16 PID altitude controller with clamped integral.
// Depends on pidalt_pkg, pidalt_mul (serial multiplier) and pidalt_div (serial divider).
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  config  | cfg_write, cfg_index, cfg_data              | in
//  input   | in_valid/in_ready: mode, measured, target,  | in
//          |   step_time                                 |
//  result  | out_valid/out_ready: drive, current_error,  | out
//          |   skipped                                   |
//
// An update word takes four products through the one bit-serial multiplier, plus
// add and clamp steps; the divide runs alongside the multiplies.
// Clear words and words with step_time <= 0 skip the arithmetic.
// Reset (rst, synchronous) loads the default gains and clamps and zeroes the state.
// The result register holds a word until taken; the next word is accepted meanwhile.
module pid_altitude_controller import pidalt_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic signed [DATA_W-1:0]    measured,
  input  logic signed [DATA_W-1:0]    target,
  input  logic signed [DATA_W-1:0]    step_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_W-1:0]    drive,
  output logic signed [DATA_W-1:0]    current_error,
  output logic                        skipped
);

  state_t state, state_next;

  logic signed [DATA_W-1:0] gain_p, gain_i, gain_d, drive_max, drive_min;
  logic [DATA_W-2:0]        sum_limit;
  logic signed [DATA_W-1:0] error_sum, previous_error;

  logic signed [DATA_W-1:0] err, dt;
  logic signed [DATA_W:0]   int_sum;
  logic signed [DATA_W+1:0] acc;
  logic                     div_neg;
  logic signed [DATA_W-1:0] res_drive, res_err;
  logic                     res_skip;

  logic                     mul_start, mul_busy;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]        mul_product;
  logic                     div_start, div_busy;
  logic [DIV_W-1:0]         div_quotient;
  logic                     out_load;

  logic                     accept;
  logic                     dt_bad;
  logic signed [DATA_W:0]   sub_in;
  logic signed [DATA_W-1:0] err_in;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          diff_mag;
  logic signed [DATA_W-1:0] term;
  logic signed [DATA_W-1:0] deriv;
  logic signed [DATA_W:0]   limit_pos;

  pidalt_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (mul_product)
  );

  pidalt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({diff_mag, {Q_FRAC{1'b0}}}),
    .divisor  (dt[DATA_W-2:0]),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign dt_bad   = step_time[DATA_W-1] || (step_time == '0);

  always_comb begin
    sub_in = {target[DATA_W-1], target} - {measured[DATA_W-1], measured};
    if (sub_in > $signed({S32_MAX[DATA_W-1], S32_MAX})) err_in = S32_MAX;
    else if (sub_in < $signed({S32_MIN[DATA_W-1], S32_MIN})) err_in = S32_MIN;
    else err_in = sub_in[DATA_W-1:0];
    diff      = {err[DATA_W-1], err} - {previous_error[DATA_W-1], previous_error};
    diff_mag  = diff[DATA_W] ? -diff : diff;
    term      = q_sat(mul_product);
    deriv     = quot_sat(div_quotient, div_neg);
    limit_pos = {2'b00, sum_limit};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (mode || dt_bad) state_next = S_DONE;
          else state_next = S_DIFF;
        end
      end
      S_DIFF:      state_next = S_MUL_E;
      S_MUL_E:     if (!mul_busy) state_next = S_INT_ADD;
      S_INT_ADD:   state_next = S_INT_CLAMP;
      S_INT_CLAMP: state_next = S_MUL_P;
      S_MUL_P:     if (!mul_busy) state_next = S_MUL_I;
      S_MUL_I:     if (!mul_busy) state_next = S_WAIT_D;
      S_WAIT_D:    if (!div_busy) state_next = S_MUL_D;
      S_MUL_D:     if (!mul_busy) state_next = S_CLAMP;
      S_CLAMP:     state_next = S_DONE;
      S_DONE:      if (!out_valid || out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // controls for the serial units and the result register
  always_comb begin
    mul_start = 1'b0;
    mul_a     = err;
    mul_b     = dt;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_DIFF: begin
        mul_start = 1'b1;
        div_start = 1'b1;
      end
      S_INT_CLAMP: begin
        mul_start = 1'b1;
        mul_a     = gain_p;
        mul_b     = err;
      end
      S_MUL_P: begin
        mul_start = !mul_busy;
        mul_a     = gain_i;
        mul_b     = error_sum;
      end
      S_WAIT_D: begin
        mul_start = !div_busy;
        mul_a     = gain_d;
        mul_b     = deriv;
      end
      S_DONE:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= 32'sd32768;
      gain_i    <= 32'sd6554;
      gain_d    <= 32'sd13107;
      drive_max <= 32'sd19661;
      drive_min <= -32'sd19661;
      sum_limit <= 31'd32768;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GAIN_P:    gain_p    <= cfg_data;
        CFG_GAIN_I:    gain_i    <= cfg_data;
        CFG_GAIN_D:    gain_d    <= cfg_data;
        CFG_DRIVE_MAX: drive_max <= cfg_data;
        CFG_DRIVE_MIN: drive_min <= cfg_data;
        CFG_INT_LIMIT: sum_limit <= cfg_data[DATA_W-2:0];
        default: ;
      endcase
    end
  end

  // controller state: integral and last error
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (accept && mode) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (state == S_DIFF) begin
      previous_error <= err;
    end else if (state == S_INT_CLAMP) begin
      if (int_sum > limit_pos) error_sum <= limit_pos[DATA_W-1:0];
      else if (int_sum < -limit_pos) error_sum <= -limit_pos[DATA_W-1:0];
      else error_sum <= int_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (accept) begin
      err <= err_in;
      dt  <= step_time;
      if (mode) begin
        res_drive <= '0;
        res_err   <= '0;
        res_skip  <= 1'b0;
      end else if (dt_bad) begin
        res_drive <= '0;
        res_err   <= previous_error;
        res_skip  <= 1'b1;
      end
    end
    unique case (state)
      S_DIFF: begin
        div_neg  <= diff[DATA_W];
        res_err  <= err;
        res_skip <= 1'b0;
      end
      S_INT_ADD: int_sum <= {error_sum[DATA_W-1], error_sum} + {term[DATA_W-1], term};
      S_MUL_P: if (!mul_busy) acc <= {{2{term[DATA_W-1]}}, term};
      S_MUL_I, S_MUL_D: if (!mul_busy) acc <= acc + {{2{term[DATA_W-1]}}, term};
      S_CLAMP: begin
        if (acc > $signed({{2{drive_max[DATA_W-1]}}, drive_max})) res_drive <= drive_max;
        else if (acc < $signed({{2{drive_min[DATA_W-1]}}, drive_min})) res_drive <= drive_min;
        else res_drive <= acc[DATA_W-1:0];
      end
      default: ;
    endcase
    if (out_load) begin
      drive         <= res_drive;
      current_error <= res_err;
      skipped       <= res_skip;
    end
  end

endmodule

[sim/tb.sv]
// Self-checking bench for pid_altitude_controller: random bursts of update, skip and
// clear words against a cycle-free PID predictor. Depends on pidalt_pkg and the RTL.
`timescale 1ns / 1ps

module tb import pidalt_pkg::*; ();

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 150;

  typedef struct packed {
    logic mode;
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] step_time;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] current_error;
    logic skipped;
  } res_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic signed [DATA_W-1:0] measured = '0;
  logic signed [DATA_W-1:0] target = '0;
  logic signed [DATA_W-1:0] step_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] drive;
  logic signed [DATA_W-1:0] current_error;
  logic skipped;

  in_word_t word_backlog[$];
  res_word_t pid_results[$];
  int fail_count = 0;
  int cycle_count = 0;

  // controller state and registers as the block should hold them
  longint kp = 32768;
  longint ki = 6554;
  longint kd = 13107;
  longint dmax = 19661;
  longint dmin = -19661;
  longint lim = 32768;
  longint integ = 0;
  longint last_err = 0;

  pid_altitude_controller DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .measured(measured), .target(target), .step_time(step_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive(drive), .current_error(current_error), .skipped(skipped)
  );

  always #5 clk = ~clk;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // >>> on a signed longint floors, as the Q16.16 product needs
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat32(p >>> 16);
  endfunction

  function automatic res_word_t pid_update(in_word_t w);
    res_word_t r;
    longint err, acc, slope, total, dt;
    r = '0;
    dt = longint'($signed(w.step_time));
    if (w.mode == MODE_CLEAR) begin
      integ = 0;
      last_err = 0;
    end else if (dt <= 0) begin
      r.current_error = 32'(last_err);
      r.skipped = 1'b1;
    end else begin
      err = sat32(longint'($signed(w.target)) - longint'($signed(w.measured)));
      acc = integ + qmul(err, dt);
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      integ = acc;
      slope = sat32(((err - last_err) * 64'sd65536) / dt);
      last_err = err;
      total = qmul(kp, err) + qmul(ki, acc) + qmul(kd, slope);
      // max is tested first, so crossed clamps favor drive_max
      if (total > dmax) total = dmax;
      else if (total < dmin) total = dmin;
      r.drive = 32'(total);
      r.current_error = 32'(err);
    end
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    case (idx)
      CFG_GAIN_P:    kp = longint'($signed(v));
      CFG_GAIN_I:    ki = longint'($signed(v));
      CFG_GAIN_D:    kd = longint'($signed(v));
      CFG_DRIVE_MAX: dmax = longint'($signed(v));
      CFG_DRIVE_MIN: dmin = longint'($signed(v));
      CFG_INT_LIMIT: lim = longint'({1'b0, v[30:0]});
      default: ;
    endcase
  endfunction

  function automatic int rnd_span(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 32'd0;
      3: return 32'hffff_ffff;
      4: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(logic m, logic [DATA_W-1:0] meas, logic [DATA_W-1:0] tgt,
                           logic [DATA_W-1:0] dt);
    in_word_t w;
    w.mode = m;
    w.measured = meas;
    w.target = tgt;
    w.step_time = dt;
    word_backlog.push_back(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    apply_reg(idx, v);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // block is idle once every word went in and every result came out
  task automatic settle();
    while (word_backlog.size() != 0 || in_valid || pid_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // a climb or descent toward a target, with the odd skipped step
  task automatic queue_flight(int n);
    int alt, goal, dt;
    goal = rnd_span(100 << 16);
    alt = rnd_span(100 << 16);
    case ($urandom_range(0, 3))
      0: dt = 655;
      1: dt = 66;
      2: dt = $urandom_range(1, 1 << 17);
      default: dt = 65536;
    endcase
    repeat (n) begin
      if ($urandom_range(0, 14) == 0)
        push_word(MODE_UPDATE, alt, goal, -int'($urandom_range(0, 1 << 16)));
      else
        push_word(MODE_UPDATE, alt, goal, dt);
      alt = alt + (goal - alt) / 8 + rnd_span(1 << 14);
      if ($urandom_range(0, 9) == 0) goal = rnd_span(100 << 16);
    end
  endtask

  task automatic queue_noise();
    case ($urandom_range(0, 5))
      0: push_word(MODE_CLEAR, $urandom, $urandom, $urandom);
      1: push_word(MODE_UPDATE, $urandom, $urandom,
                   $urandom_range(0, 1) ? 32'd0 : {1'b1, 31'($urandom)});
      2: push_word(MODE_UPDATE, $urandom, $urandom, {1'b0, 31'($urandom)});
      3: push_word(MODE_UPDATE, pick_extreme(), pick_extreme(), pick_extreme());
      4: push_word(MODE_UPDATE, $urandom, $urandom, $urandom_range(1, 4));
      default: push_word(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
    endcase
  endtask

  task automatic queue_random(int n);
    int made, k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 3) != 0) begin
        k = $urandom_range(4, 20);
        queue_flight(k);
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) queue_noise();
      end
      made += k;
    end
  endtask

  task automatic program_phase(int ph);
    case (ph)
      1: begin
        write_reg(CFG_GAIN_P, 32'h0001_0000);
        write_reg(CFG_GAIN_I, 32'h0001_0000);
        write_reg(CFG_GAIN_D, 32'h0001_0000);
        write_reg(CFG_DRIVE_MAX, S32_MAX);
        write_reg(CFG_DRIVE_MIN, S32_MIN);
        write_reg(CFG_INT_LIMIT, 32'hffff_ffff);
      end
      2: begin
        write_reg(CFG_GAIN_P, S32_MIN);
        write_reg(CFG_GAIN_I, S32_MAX);
        write_reg(CFG_GAIN_D, 32'hffff_ffff);
        write_reg(CFG_DRIVE_MAX, 32'h0001_0000);
        write_reg(CFG_DRIVE_MIN, -32'sh0001_0000);
        write_reg(CFG_INT_LIMIT, 32'd0);
      end
      3: begin
        // crossed clamps
        write_reg(CFG_GAIN_P, rnd_span(1 << 17));
        write_reg(CFG_GAIN_I, rnd_span(1 << 17));
        write_reg(CFG_GAIN_D, rnd_span(1 << 17));
        write_reg(CFG_DRIVE_MAX, -32'sd32768);
        write_reg(CFG_DRIVE_MIN, 32'sd32768);
        write_reg(CFG_INT_LIMIT, 32'd1 << 18);
      end
      4: begin
        write_reg(CFG_GAIN_P, $urandom);
        write_reg(CFG_GAIN_I, $urandom);
        write_reg(CFG_GAIN_D, $urandom);
        write_reg(CFG_DRIVE_MAX, $urandom);
        write_reg(CFG_DRIVE_MIN, $urandom);
        write_reg(CFG_INT_LIMIT, $urandom);
        // unmapped indexes must not disturb anything
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
      end
      default: begin
        write_reg(CFG_GAIN_P, rnd_span(1 << 18));
        write_reg(CFG_GAIN_I, rnd_span(1 << 18));
        write_reg(CFG_GAIN_D, rnd_span(1 << 18));
        write_reg(CFG_DRIVE_MAX, $urandom_range(0, 1 << 22));
        write_reg(CFG_DRIVE_MIN, -int'($urandom_range(0, 1 << 22)));
        write_reg(CFG_INT_LIMIT, $urandom_range(0, 1 << 20));
      end
    endcase
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset settings
    push_word(MODE_UPDATE, 32'd0, 32'h0001_0000, 32'h0001_0000);
    push_word(MODE_UPDATE, 32'h0000_8000, 32'h0001_0000, 32'd655);
    push_word(MODE_UPDATE, 32'd0, 32'h0002_0000, 32'd0);
    push_word(MODE_UPDATE, 32'd0, 32'h0002_0000, -32'sh0001_0000);
    push_word(MODE_UPDATE, 32'd0, 32'h0002_0000, S32_MIN);
    push_word(MODE_UPDATE, S32_MIN, S32_MAX, 32'd1);
    push_word(MODE_UPDATE, S32_MAX, S32_MIN, S32_MAX);
    push_word(MODE_CLEAR, $urandom, $urandom, $urandom);
    push_word(MODE_UPDATE, 32'hffff_ffff, 32'd0, 32'd1);
    push_word(MODE_UPDATE, 32'd0, 32'd0, 32'd1);
    repeat (3) push_word(MODE_UPDATE, 32'd0, 32'h000a_0000, 32'h0001_0000);
    repeat (3) push_word(MODE_UPDATE, 32'd0, -32'sh000a_0000, 32'h0001_0000);
    push_word(MODE_CLEAR, 32'd0, 32'd0, 32'd0);
    push_word(MODE_UPDATE, 32'h0001_0000, 32'd0, 32'h0001_0000);
    push_word(MODE_UPDATE, 32'd0, 32'h0000_0100, S32_MAX);
    push_word(MODE_UPDATE, 32'h5555_5555, 32'haaaa_aaaa, 32'h0001_0000);
    push_word(MODE_UPDATE, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001);
    push_word(MODE_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        program_phase(ph);
      end
      queue_random(PHASE_WORDS);
    end

    settle();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("pid_altitude_controller regression: pass");
    end else begin
      $display("pid_altitude_controller regression: fail");
    end
    $finish;
  end

  // sender: bursts of words separated by gaps of random length
  always @(posedge clk) begin : feeder
    in_word_t nxt;
    int gap_left;
    int burst_left;
    in_word_t held_word;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_valid && in_ready) pid_results.push_back(pid_update(held_word));
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || word_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          nxt = word_backlog.pop_front();
          held_word = nxt;
          in_valid <= 1'b1;
          mode <= nxt.mode;
          measured <= nxt.measured;
          target <= nxt.target;
          step_time <= nxt.step_time;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: gap_left = 0;
              5, 6, 7: gap_left = $urandom_range(1, 6);
              8: gap_left = $urandom_range(7, 40);
              default: gap_left = $urandom_range(40, 180);
            endcase
          end
        end
      end
    end
  end

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // receiver: varying ready density plus a long hold-off now and then
  always @(posedge clk) begin : collector
    res_word_t want;
    int words_seen;
    int hold_left;
    int ready_pct;
    if (rst) begin
      out_ready <= 1'b0;
      words_seen = 0;
      hold_left = 0;
      ready_pct = 100;
    end else begin
      if (out_valid && out_ready) begin
        if (pid_results.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, got drive=%h error=%h skipped=%b",
                   $time, drive, current_error, skipped);
          fail_count++;
        end else begin
          want = pid_results.pop_front();
          check_field("drive", want.drive, drive);
          check_field("current_error", want.current_error, current_error);
          check_field("skipped", {31'd0, want.skipped}, {31'd0, skipped});
        end
        words_seen++;
        if (words_seen % 300 == 40) hold_left = 3000;
        if (words_seen % 50 == 0) begin
          case ($urandom_range(0, 4))
            0, 1: ready_pct = 100;
            2: ready_pct = 75;
            3: ready_pct = 40;
            default: ready_pct = 10;
          endcase
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("pid_altitude_controller regression: fail");
      $finish;
    end
  end

endmodule

[files.f]
sv/pidalt_pkg.sv
sv/pidalt_mul.sv
sv/pidalt_div.sv
sv/pid_altitude_controller.sv
sim/tb.sv
